@@ src/mpc_pkg.sv @@
package mpc_pkg;

	// Default depth of the pair store.
	localparam int MAX_PAIRS_DEF = 4096;

	// Fixed widths of the datapath.
	localparam int SAMPLE_W = 24;
	localparam int DEV_W    = SAMPLE_W + 1;
	localparam int PROD_W   = 2 * DEV_W;
	localparam int ACC_W    = 62;
	localparam int MAG_W    = ACC_W - 1;
	localparam int WIDE_W   = 2 * MAG_W;
	localparam int ROOT_W   = 30;
	localparam int Q_W      = ROOT_W + 1;
	localparam int CORR_W   = 32;
	localparam int STATUS_W = 2;

	// Reset value of the missing-sample code.
	localparam logic signed [SAMPLE_W-1:0] UNDEF_RESET = 24'sh800000;

	// Saturation limits of the accumulators, one bit wider than them.
	localparam logic signed [ACC_W:0] ACC_POS = 63'sd2305843009213693951;
	localparam logic signed [ACC_W:0] ACC_NEG = -63'sd2305843009213693951;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

	// Request to the ratio unit.
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] cov_mag;
		logic [MAG_W-1:0] var_a;
		logic [MAG_W-1:0] var_b;
	} ratio_req_t;

	// Saturating accumulate of one product.
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  acc,
		input logic signed [PROD_W-1:0] x
	);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(acc) + (ACC_W+1)'(x);
		if (s > ACC_POS) begin
			s = ACC_POS;
		end else if (s < ACC_NEG) begin
			s = ACC_NEG;
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

@@ src/mpc_mean.sv @@
module mpc_mean import mpc_pkg::*; #(
	parameter int SUM_W = SAMPLE_W + 13,
	parameter int CNT_W = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_W-1:0]    sum,
	input  logic        [CNT_W-1:0]    count,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] mean
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;
	logic signed [SAMPLE_W-1:0] mean_q;

	logic [SUM_W-1:0]  mag;
	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    rem_sub;
	logic [SUM_W-1:0]  fix;

	// Magnitude of the sum; the most negative value reads correctly as unsigned.
	assign mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

	// One quotient bit per cycle by restoring division.
	assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Floor for a negative sum: negate and step down when a remainder is left.
	assign fix = neg_q ? (~quo_q + SUM_W'(1) - {{(SUM_W-1){1'b0}}, |rem_q}) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(SUM_W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= count;
			neg_q <= sum[SUM_W-1];
		end else if (busy_q) begin
			if (step_q == STEP_W'(SUM_W)) begin
				mean_q <= fix[SAMPLE_W-1:0];
			end else begin
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
				quo_q <= {quo_q[SUM_W-2:0], ge};
				rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign mean = mean_q;

endmodule

@@ src/mpc_ratio.sv @@
module mpc_ratio import mpc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  ratio_req_t     req,
	output logic           done,
	output logic [Q_W-1:0] q
);

	localparam logic [2:0] R_IDLE  = 3'd0;
	localparam logic [2:0] R_MULP  = 3'd1;
	localparam logic [2:0] R_MULC  = 3'd2;
	localparam logic [2:0] R_CHECK = 3'd3;
	localparam logic [2:0] R_DIV   = 3'd4;
	localparam logic [2:0] R_SQRT  = 3'd5;

	localparam int LIMB_W = 31;
	localparam int X_W    = 2 * ROOT_W;

	logic [2:0]        phase_q;
	logic              done_q;
	logic [5:0]        step_q;
	logic [2:0]        mstep_q;
	logic [1:0]        pk_q;
	logic [2*LIMB_W-1:0] pp_q;
	logic [WIDE_W-1:0] acc_q;
	logic [MAG_W-1:0]  cov_q;
	logic [MAG_W-1:0]  va_q;
	logic [MAG_W-1:0]  vb_q;
	logic [WIDE_W-1:0] p_q;
	logic [WIDE_W-1:0] c2_q;
	logic [WIDE_W:0]   rem_q;
	logic [X_W-1:0]    x_q;
	logic [31:0]       srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [Q_W-1:0]    q_q;

	logic [MAG_W-1:0]  op_a;
	logic [MAG_W-1:0]  op_b;
	logic [LIMB_W-1:0] limb_a;
	logic [LIMB_W-1:0] limb_b;
	logic [WIDE_W-1:0] pp_ext;
	logic [WIDE_W-1:0] acc_next;
	logic [WIDE_W:0]   r2;
	logic              dge;
	logic [33:0]       s_sh;
	logic [33:0]       s_trial;
	logic              sge;
	logic [33:0]       s_sub;

	// Operands of the shared multiplier: the variances, then the covariance squared.
	assign op_a = (phase_q == R_MULP) ? va_q : cov_q;
	assign op_b = (phase_q == R_MULP) ? vb_q : cov_q;

	// Partial products in the order lo*lo, lo*hi, hi*lo, hi*hi.
	assign limb_a = mstep_q[1] ? {1'b0, op_a[MAG_W-1:LIMB_W]} : op_a[LIMB_W-1:0];
	assign limb_b = mstep_q[0] ? {1'b0, op_b[MAG_W-1:LIMB_W]} : op_b[LIMB_W-1:0];

	// Place the registered partial product at its weight.
	always_comb begin
		pp_ext = {{(WIDE_W-2*LIMB_W){1'b0}}, pp_q};
		case (pk_q)
			2'd0:    pp_ext = pp_ext;
			2'd3:    pp_ext = pp_ext << (2 * LIMB_W);
			default: pp_ext = pp_ext << LIMB_W;
		endcase
	end
	assign acc_next = acc_q + pp_ext;

	// One quotient bit of c2 * 2^60 / p per cycle.
	assign r2  = {rem_q[WIDE_W-1:0], 1'b0};
	assign dge = r2 >= {1'b0, p_q};

	// One root bit per cycle, two radicand bits consumed.
	assign s_sh    = {srem_q, x_q[X_W-1:X_W-2]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign sge     = s_sh >= s_trial;
	assign s_sub   = s_sh - s_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= R_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
			mstep_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				R_IDLE: begin
					if (req.start) begin
						phase_q <= R_MULP;
						mstep_q <= '0;
					end
				end
				R_MULP: begin
					if (mstep_q == 3'd4) begin
						mstep_q <= '0;
						phase_q <= R_MULC;
					end else begin
						mstep_q <= mstep_q + 3'd1;
					end
				end
				R_MULC: begin
					if (mstep_q == 3'd4) begin
						mstep_q <= '0;
						phase_q <= R_CHECK;
					end else begin
						mstep_q <= mstep_q + 3'd1;
					end
				end
				R_CHECK: begin
					step_q <= '0;
					if (c2_q >= p_q) begin
						done_q  <= 1'b1;
						phase_q <= R_IDLE;
					end else begin
						phase_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (step_q == 6'(X_W - 1)) begin
						step_q  <= '0;
						phase_q <= R_SQRT;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				R_SQRT: begin
					if (step_q == 6'(ROOT_W - 1)) begin
						done_q  <= 1'b1;
						phase_q <= R_IDLE;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				default: begin
					phase_q <= R_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (phase_q)
			R_IDLE: begin
				if (req.start) begin
					cov_q <= req.cov_mag;
					va_q  <= req.var_a;
					vb_q  <= req.var_b;
					acc_q <= '0;
				end
			end
			R_MULP, R_MULC: begin
				if (mstep_q != 3'd4) begin
					pp_q <= limb_a * limb_b;
					pk_q <= mstep_q[1:0];
				end
				if (mstep_q == 3'd4) begin
					acc_q <= '0;
					if (phase_q == R_MULP) begin
						p_q <= acc_next;
					end else begin
						c2_q <= acc_next;
					end
				end else if (mstep_q != 3'd0) begin
					acc_q <= acc_next;
				end
			end
			R_CHECK: begin
				rem_q  <= {1'b0, c2_q};
				x_q    <= '0;
				srem_q <= '0;
				root_q <= '0;
				if (c2_q >= p_q) begin
					q_q <= Q_W'(1) << ROOT_W;
				end
			end
			R_DIV: begin
				rem_q <= dge ? (r2 - {1'b0, p_q}) : r2;
				x_q   <= {x_q[X_W-2:0], dge};
			end
			R_SQRT: begin
				x_q    <= {x_q[X_W-3:0], 2'b00};
				srem_q <= sge ? s_sub[31:0] : s_sh[31:0];
				root_q <= {root_q[ROOT_W-2:0], sge};
				if (step_q == 6'(ROOT_W - 1)) begin
					q_q <= {1'b0, root_q[ROOT_W-2:0], sge};
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

@@ src/masked_pearson_correlation.sv @@
// Pairs load at one per cycle; in_ready is high while the block collects a series.
// After the last pair: one decision state, then (unless the series overflowed or has too few
// pairs) the two mean divisions, a second pass through the pair memory, one check state and,
// for nonzero variances, the ratio unit (two multiplies, 60 divide steps, 30 root steps).
// Only one series is worked on at a time. Reset clears control state and the series
// sums and sets the missing-sample code to -8388608; the pair memory is not cleared.
module masked_pearson_correlation import mpc_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic signed [SAMPLE_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_a,
	input  logic signed [SAMPLE_W-1:0] sample_b,
	input  logic                       last_pair,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [CORR_W-1:0]   correlation_q30,
	output logic [STATUS_W-1:0]        status
);

	localparam int ADDR_W = $clog2(MAX_PAIRS);
	localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_MEAN  = 3'd2;
	localparam logic [2:0] S_PASS  = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_RATIO = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]                 state_q;
	logic signed [SAMPLE_W-1:0] undef_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [SUM_W-1:0]    sum_a_q;
	logic signed [SUM_W-1:0]    sum_b_q;
	logic                       ovf_q;
	logic [CNT_W-1:0]           rd_cnt_q;
	logic signed [ACC_W-1:0]    cov_q;
	logic signed [ACC_W-1:0]    var_a_q;
	logic signed [ACC_W-1:0]    var_b_q;
	logic signed [CORR_W-1:0]   res_corr_q;
	logic [STATUS_W-1:0]        res_status_q;
	logic                       out_valid_q;
	logic signed [CORR_W-1:0]   out_corr_q;
	logic [STATUS_W-1:0]        out_status_q;

	logic [2*SAMPLE_W-1:0]      mem [MAX_PAIRS];

	logic                       rd_v_s1;
	logic [2*SAMPLE_W-1:0]      rd_data_s1;
	logic                       dev_v_s2;
	logic signed [DEV_W-1:0]    da_s2;
	logic signed [DEV_W-1:0]    db_s2;
	logic                       prod_v_s3;
	logic signed [PROD_W-1:0]   pab_s3;
	logic signed [PROD_W-1:0]   paa_s3;
	logic signed [PROD_W-1:0]   pbb_s3;

	logic                       accept;
	logic                       keep;
	logic                       room;
	logic                       wr_en;
	logic                       issue;
	logic                       pass_end;
	logic                       out_free;
	logic                       mean_start;
	logic                       done_a;
	logic                       done_b;
	logic signed [SAMPLE_W-1:0] mean_a;
	logic signed [SAMPLE_W-1:0] mean_b;
	logic signed [SAMPLE_W-1:0] rd_a;
	logic signed [SAMPLE_W-1:0] rd_b;
	logic signed [ACC_W-1:0]    cov_neg;
	ratio_req_t                 ratio_req;
	logic                       ratio_done;
	logic [Q_W-1:0]             ratio_q;

	// Input handshake and the keep decision for one pair.
	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;
	assign keep     = (sample_a != undef_q) && (sample_b != undef_q);
	assign room     = count_q < CNT_W'(MAX_PAIRS);
	assign wr_en    = accept && keep && room;

	// Second pass read control.
	assign issue    = (state_q == S_PASS) && (rd_cnt_q < count_q);
	assign pass_end = (state_q == S_PASS) && !issue && !rd_v_s1 && !dev_v_s2 && !prod_v_s3;
	assign out_free = !out_valid_q || out_ready;

	assign mean_start = (state_q == S_EVAL) && !ovf_q && (count_q >= CNT_W'(2));

	assign rd_a    = rd_data_s1[2*SAMPLE_W-1:SAMPLE_W];
	assign rd_b    = rd_data_s1[SAMPLE_W-1:0];
	assign cov_neg = -cov_q;

	// Ratio request once the variances are known to be nonzero.
	always_comb begin
		ratio_req.start   = (state_q == S_CHK) && (var_a_q != '0) && (var_b_q != '0);
		ratio_req.cov_mag = cov_q[ACC_W-1] ? cov_neg[MAG_W-1:0] : cov_q[MAG_W-1:0];
		ratio_req.var_a   = var_a_q[MAG_W-1:0];
		ratio_req.var_b   = var_b_q[MAG_W-1:0];
	end

	// Pair memory: written while loading, read once per pair in the second pass.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= {sample_a, sample_b};
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_cnt_q[ADDR_W-1:0]];
		end
	end

	// Mean dividers for the two series.
	mpc_mean #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_mean_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mean_start),
		.sum    (sum_a_q),
		.count  (count_q),
		.done   (done_a),
		.mean   (mean_a)
	);

	mpc_mean #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_mean_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mean_start),
		.sum    (sum_b_q),
		.count  (count_q),
		.done   (done_b),
		.mean   (mean_b)
	);

	// Coefficient from the accumulated moments.
	mpc_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ratio_req),
		.done   (ratio_done),
		.q      (ratio_q)
	);

	// Control, series state and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			undef_q     <= UNDEF_RESET;
			count_q     <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			ovf_q       <= 1'b0;
			rd_cnt_q    <= '0;
			rd_v_s1     <= 1'b0;
			dev_v_s2    <= 1'b0;
			prod_v_s3   <= 1'b0;
			cov_q       <= '0;
			var_a_q     <= '0;
			var_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				undef_q <= cfg_wr_data;
			end

			rd_v_s1   <= issue;
			dev_v_s2  <= rd_v_s1;
			prod_v_s3 <= dev_v_s2;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (prod_v_s3) begin
				cov_q   <= sat_add(cov_q, pab_s3);
				var_a_q <= sat_add(var_a_q, paa_s3);
				var_b_q <= sat_add(var_b_q, pbb_s3);
			end

			// A result leaving while the next one is issued is handled in S_OUT.
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (wr_en) begin
							count_q <= count_q + CNT_W'(1);
							sum_a_q <= sum_a_q + SUM_W'(sample_a);
							sum_b_q <= sum_b_q + SUM_W'(sample_b);
						end else if (keep) begin
							ovf_q <= 1'b1;
						end
						if (last_pair) begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (mean_start) begin
						state_q <= S_MEAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MEAN: begin
					rd_cnt_q <= '0;
					cov_q    <= '0;
					var_a_q  <= '0;
					var_b_q  <= '0;
					if (done_a && done_b) begin
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					if (pass_end) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (ratio_req.start) begin
						state_q <= S_RATIO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_RATIO: begin
					if (ratio_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						sum_a_q     <= '0;
						sum_b_q     <= '0;
						ovf_q       <= 1'b0;
						cov_q       <= '0;
						var_a_q     <= '0;
						var_b_q     <= '0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Deviation and product stages of the second pass.
	always_ff @(posedge clk) begin
		da_s2  <= DEV_W'(rd_a) - DEV_W'(mean_a);
		db_s2  <= DEV_W'(rd_b) - DEV_W'(mean_b);
		pab_s3 <= da_s2 * db_s2;
		paa_s3 <= da_s2 * da_s2;
		pbb_s3 <= db_s2 * db_s2;
	end

	// Result selection, with overflow ahead of the other cases.
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			res_corr_q <= '0;
			if (ovf_q) begin
				res_status_q <= ST_OVERFLOW;
			end else begin
				res_status_q <= ST_TOO_FEW;
			end
		end else if (state_q == S_CHK) begin
			res_corr_q   <= '0;
			res_status_q <= ST_ZERO_VAR;
		end else if (state_q == S_RATIO && ratio_done) begin
			res_status_q <= ST_OK;
			if (cov_q[ACC_W-1]) begin
				res_corr_q <= -CORR_W'(ratio_q);
			end else begin
				res_corr_q <= CORR_W'(ratio_q);
			end
		end
		if (state_q == S_OUT && out_free) begin
			out_corr_q   <= res_corr_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign correlation_q30 = out_corr_q;
	assign status          = out_status_q;

endmodule
